// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, reset on rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHECK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/m4vt_pkg.sv
// ---------------------------------------------------------------------------
// m4vt_pkg
// Types, command codes and defaults of the 4x4 vertex transform unit.
// ---------------------------------------------------------------------------
package m4vt_pkg;

    localparam int WORD_W        = 32;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [2:0]               cmd_t;
    typedef logic [1:0]               idx_t;

    localparam cmd_t CMD_WRITE = 3'd0;
    localparam cmd_t CMD_READ  = 3'd1;
    localparam cmd_t CMD_XFORM = 3'd2;
    localparam cmd_t CMD_TRANS = 3'd3;
    localparam cmd_t CMD_SCALE = 3'd4;
    localparam cmd_t CMD_IDENT = 3'd5;

endpackage

// File: src/m4vt_req_if.sv
// ---------------------------------------------------------------------------
// m4vt_req_if
// Command channel: valid/ready plus command, element index and vector.
// ---------------------------------------------------------------------------
interface m4vt_req_if;
    import m4vt_pkg::*;

    logic  valid;
    logic  ready;
    cmd_t  cmd;
    idx_t  row;
    idx_t  col;
    word_t vec_x;
    word_t vec_y;
    word_t vec_z;
    word_t vec_w;

    modport source (output valid, cmd, row, col, vec_x, vec_y, vec_z, vec_w, input ready);
    modport sink   (input valid, cmd, row, col, vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

// File: src/m4vt_rsp_if.sv
// ---------------------------------------------------------------------------
// m4vt_rsp_if
// Result channel: valid/ready plus four Q words and the overflow flag.
// ---------------------------------------------------------------------------
interface m4vt_rsp_if;
    import m4vt_pkg::*;

    logic  valid;
    logic  ready;
    word_t res_x;
    word_t res_y;
    word_t res_z;
    word_t res_w;
    logic  overflow;

    modport source (output valid, res_x, res_y, res_z, res_w, overflow, input ready);
    modport sink   (input valid, res_x, res_y, res_z, res_w, overflow, output ready);
endinterface

// File: src/matrix4_vertex_transform_unit.sv
// ---------------------------------------------------------------------------
// matrix4_vertex_transform_unit
// 4x4 Q-format transform matrix: element access, vertex transform,
// translate/scale compose and identity reload.
// ---------------------------------------------------------------------------
//  channel | dir | word
//  --------+-----+-------------------------------------------------
//  req     | in  | cmd, row, col, vec_x, vec_y, vec_z, vec_w
//  rsp     | out | res_x, res_y, res_z, res_w, overflow
//
//  Three register stages: input word, product array, result word; a command
//  word passes through them in that order on its way to rsp.
//  Transforms and reads stream at one word per cycle while rsp stays ready.
//  A command that changes the matrix (write, translate, scale, identity)
//  holds the next word in the input stage until the matrix update in the
//  product stage has landed.
//  rsp stalls back up stage by stage; rst_n reloads the identity.
// ---------------------------------------------------------------------------
module matrix4_vertex_transform_unit #(
    parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    m4vt_req_if.sink     req,
    m4vt_rsp_if.source   rsp
);
    import m4vt_pkg::*;

    `include "assert_macros.svh"

    localparam int    PW  = 2 * WORD_W - FRAC_BITS;
    localparam word_t ONE = word_t'(1) << FRAC_BITS;

    // stage A: input word
    logic        a_valid_reg;
    cmd_t        a_cmd_reg;
    idx_t        a_row_reg;
    idx_t        a_col_reg;
    word_t       a_vec_reg [4];

    // stage B: products
    logic        b_valid_reg;
    cmd_t        b_cmd_reg;
    logic [3:0]  b_idx_reg;
    word_t       b_wval_reg;
    word_t       b_rd_reg;
    logic signed [PW-1:0] b_prod_reg [16];

    // stage C: result word
    logic        c_valid_reg;
    word_t       res_reg [4];
    logic        ovf_reg;

    word_t       mat_reg  [16];
    word_t       mat_next [16];
    word_t       res_next [4];
    logic        ovf_next;

    logic signed [PW-1:0] prod [16];
    word_t       row_sum  [4];
    logic [3:0]  row_ovf;
    word_t       elem_sat [16];
    logic [15:0] elem_ovf;

    logic c_free, b_adv, b_free, b_mod, a_adv, a_free, a_take;
    logic ident_ok, b_access, b_is_write;

    assign b_mod  = (b_cmd_reg == CMD_WRITE) || (b_cmd_reg == CMD_TRANS) ||
                    (b_cmd_reg == CMD_SCALE) || (b_cmd_reg == CMD_IDENT);
    assign c_free = !c_valid_reg || rsp.ready;
    assign b_adv  = b_valid_reg && c_free;
    assign b_free = !b_valid_reg || b_adv;
    // matrix is read when a word moves A->B, so wait out any pending update
    assign a_adv  = a_valid_reg && b_free && !(b_valid_reg && b_mod);
    assign a_free = !a_valid_reg || a_adv;
    assign a_take = req.valid && a_free;

    assign req.ready = a_free;

    m4vt_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .mat  (mat_reg),
        .vec  (a_vec_reg),
        .prod (prod)
    );

    m4vt_sat #(.FRAC_BITS(FRAC_BITS)) u_sat (
        .prod     (b_prod_reg),
        .row_sum  (row_sum),
        .row_ovf  (row_ovf),
        .elem_sat (elem_sat),
        .elem_ovf (elem_ovf)
    );

    always_comb
    begin
        mat_next = mat_reg;
        for (int i = 0; i < 4; i++)
        begin
            res_next[i] = '0;
        end
        ovf_next = 1'b0;
        case (b_cmd_reg)
            CMD_WRITE:
            begin
                mat_next[b_idx_reg] = b_wval_reg;
            end
            CMD_READ:
            begin
                res_next[0] = b_rd_reg;
            end
            CMD_XFORM:
            begin
                res_next = row_sum;
                ovf_next = |row_ovf;
            end
            CMD_TRANS:
            begin
                for (int r = 0; r < 4; r++)
                begin
                    mat_next[r*4+3] = row_sum[r];
                end
                ovf_next = |row_ovf;
            end
            CMD_SCALE:
            begin
                mat_next = elem_sat;
                ovf_next = |elem_ovf;
            end
            CMD_IDENT:
            begin
                for (int n = 0; n < 16; n++)
                begin
                    mat_next[n] = ((n % 5) == 0) ? ONE : '0;
                end
            end
            default:
            begin
                ovf_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            for (int n = 0; n < 16; n++)
            begin
                mat_reg[n] <= ((n % 5) == 0) ? ONE : '0;
            end
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= req.valid;
            end
            if (b_free)
            begin
                b_valid_reg <= a_adv;
            end
            if (c_free)
            begin
                c_valid_reg <= b_adv;
            end
            if (b_adv)
            begin
                mat_reg <= mat_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            a_cmd_reg    <= req.cmd;
            a_row_reg    <= req.row;
            a_col_reg    <= req.col;
            a_vec_reg[0] <= req.vec_x;
            a_vec_reg[1] <= req.vec_y;
            a_vec_reg[2] <= req.vec_z;
            a_vec_reg[3] <= req.vec_w;
        end
        if (a_adv)
        begin
            b_cmd_reg  <= a_cmd_reg;
            b_idx_reg  <= {a_row_reg, a_col_reg};
            b_wval_reg <= a_vec_reg[0];
            b_rd_reg   <= mat_reg[{a_row_reg, a_col_reg}];
            b_prod_reg <= prod;
        end
        if (b_adv)
        begin
            res_reg <= res_next;
            ovf_reg <= ovf_next;
        end
    end

    assign rsp.valid    = c_valid_reg;
    assign rsp.res_x    = res_reg[0];
    assign rsp.res_y    = res_reg[1];
    assign rsp.res_z    = res_reg[2];
    assign rsp.res_w    = res_reg[3];
    assign rsp.overflow = ovf_reg;

    assign ident_ok   = (mat_reg[0] == ONE) && (mat_reg[5] == ONE) &&
                        (mat_reg[10] == ONE) && (mat_reg[15] == ONE);
    assign b_access   = (b_cmd_reg == CMD_WRITE) || (b_cmd_reg == CMD_READ) ||
                        (b_cmd_reg == CMD_IDENT);
    assign b_is_write = b_adv && (b_cmd_reg == CMD_WRITE);

    `CHECK_SAME(a_no_read_past_update, b_valid_reg && b_mod, !a_adv)
    `CHECK_NEXT(b_hold_on_stall, b_valid_reg && !b_adv, b_valid_reg)
    `CHECK_NEXT(ident_diag, b_adv && (b_cmd_reg == CMD_IDENT), ident_ok)
    `CHECK_NEXT(no_ovf_on_access, b_adv && b_access, !ovf_reg)
    `CHECK_NEXT(write_lands, b_is_write, mat_reg[$past(b_idx_reg)] == $past(b_wval_reg))
endmodule

// File: src/m4vt_mul.sv
// ---------------------------------------------------------------------------
// m4vt_mul
// Sixteen element-by-component products, each floored to the Q format.
// ---------------------------------------------------------------------------
module m4vt_mul #(
    parameter int  FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF,
    localparam int PW        = 2 * m4vt_pkg::WORD_W - FRAC_BITS
) (
    input  m4vt_pkg::word_t    mat  [16],
    input  m4vt_pkg::word_t    vec  [4],
    output logic signed [PW-1:0] prod [16]
);
    import m4vt_pkg::*;

    logic signed [2*WORD_W-1:0] full [16];

    // arithmetic shift of the exact product is a floor
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                full[r*4+k] = mat[r*4+k] * vec[k];
                prod[r*4+k] = PW'(full[r*4+k] >>> FRAC_BITS);
            end
        end
    end
endmodule

// File: src/m4vt_sat.sv
// ---------------------------------------------------------------------------
// m4vt_sat
// Row sums and per-element clamps of the floored products to 32 bits.
// ---------------------------------------------------------------------------
module m4vt_sat #(
    parameter int  FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF,
    localparam int PW        = 2 * m4vt_pkg::WORD_W - FRAC_BITS
) (
    input  logic signed [PW-1:0] prod     [16],
    output m4vt_pkg::word_t      row_sum  [4],
    output logic [3:0]           row_ovf,
    output m4vt_pkg::word_t      elem_sat [16],
    output logic [15:0]          elem_ovf
);
    import m4vt_pkg::*;

    localparam int SW = PW + 2;

    logic signed [SW-1:0] smax;
    logic signed [SW-1:0] smin;
    logic signed [SW-1:0] sum  [4];
    logic signed [SW-1:0] pext [16];

    assign smax = SW'($signed({1'b0, {(WORD_W-1){1'b1}}}));
    assign smin = SW'($signed({1'b1, {(WORD_W-1){1'b0}}}));

    always_comb
    begin
        for (int n = 0; n < 16; n++)
        begin
            pext[n] = SW'(prod[n]);
            if (pext[n] > smax)
            begin
                elem_sat[n] = smax[WORD_W-1:0];
                elem_ovf[n] = 1'b1;
            end
            else if (pext[n] < smin)
            begin
                elem_sat[n] = smin[WORD_W-1:0];
                elem_ovf[n] = 1'b1;
            end
            else
            begin
                elem_sat[n] = pext[n][WORD_W-1:0];
                elem_ovf[n] = 1'b0;
            end
        end
        for (int r = 0; r < 4; r++)
        begin
            sum[r] = pext[r*4] + pext[r*4+1] + pext[r*4+2] + pext[r*4+3];
            if (sum[r] > smax)
            begin
                row_sum[r] = smax[WORD_W-1:0];
                row_ovf[r] = 1'b1;
            end
            else if (sum[r] < smin)
            begin
                row_sum[r] = smin[WORD_W-1:0];
                row_ovf[r] = 1'b1;
            end
            else
            begin
                row_sum[r] = sum[r][WORD_W-1:0];
                row_ovf[r] = 1'b0;
            end
        end
    end
endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for matrix4_vertex_transform_unit. A queue of command
// words feeds a clocked driver; an in-bench matrix model predicts each result
// at acceptance and a clocked monitor compares every returned word against
// the oldest prediction. Runs directed corners, then random command streams
// under four sender/receiver idling mixes.
// ---------------------------------------------------------------------------
module tb;
    import m4vt_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;

    localparam cmd_t  CMD_RSVD6 = 3'd6;
    localparam cmd_t  CMD_RSVD7 = 3'd7;

    localparam word_t Q_ONE = word_t'(1 << FRAC);
    localparam word_t Q_MAX = 32'h7fff_ffff;
    localparam word_t Q_MIN = 32'h8000_0000;

    localparam logic signed [63:0] SUM_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SUM_MIN = -64'sd2147483648;

    typedef struct packed {
        cmd_t  cmd;
        idx_t  row;
        idx_t  col;
        word_t x;
        word_t y;
        word_t z;
        word_t w;
    } cmd_word_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
        word_t w;
        logic  ovf;
    } result_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    m4vt_req_if req_ch ();
    m4vt_rsp_if rsp_ch ();

    cmd_word_t drv_word   = '0;
    logic      drv_valid  = 1'b0;
    logic      sink_ready = 1'b0;

    assign req_ch.valid = drv_valid;
    assign req_ch.cmd   = drv_word.cmd;
    assign req_ch.row   = drv_word.row;
    assign req_ch.col   = drv_word.col;
    assign req_ch.vec_x = drv_word.x;
    assign req_ch.vec_y = drv_word.y;
    assign req_ch.vec_z = drv_word.z;
    assign req_ch.vec_w = drv_word.w;
    assign rsp_ch.ready = sink_ready;

    matrix4_vertex_transform_unit #(
        .FRAC_BITS (FRAC)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    cmd_word_t    cmd_backlog [$];
    result_word_t pending_results [$];
    word_t        xf_mat [16];
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           queued_cnt     = 0;
    int           mismatch_cnt   = 0;

    // ---------------------------------------------------------------- model

    function automatic void load_identity();
        for (int i = 0; i < 16; i++)
        begin
            xf_mat[i] = (i % 5 == 0) ? Q_ONE : '0;
        end
    endfunction

    // exact 64-bit product, arithmetic shift gives the floor
    function automatic logic signed [63:0] q_mul(word_t a, word_t b);
        logic signed [63:0] aa;
        logic signed [63:0] bb;
        aa = a;
        bb = b;
        return (aa * bb) >>> FRAC;
    endfunction

    function automatic word_t clamp32(logic signed [63:0] s, inout logic ovf);
        if (s > SUM_MAX)
        begin
            ovf = 1'b1;
            return Q_MAX;
        end
        if (s < SUM_MIN)
        begin
            ovf = 1'b1;
            return Q_MIN;
        end
        return word_t'(s[31:0]);
    endfunction

    function automatic word_t dot_row(int r, word_t v [4], inout logic ovf);
        logic signed [63:0] acc;
        acc = '0;
        for (int k = 0; k < 4; k++)
        begin
            acc += q_mul(xf_mat[r*4 + k], v[k]);
        end
        return clamp32(acc, ovf);
    endfunction

    function automatic result_word_t apply_command(cmd_word_t c);
        result_word_t r;
        word_t        v [4];
        word_t        lane [4];
        word_t        col3 [4];
        logic         ovf;
        v    = '{c.x, c.y, c.z, c.w};
        lane = '{default: '0};
        ovf  = 1'b0;
        case (c.cmd)
            CMD_WRITE: xf_mat[{c.row, c.col}] = c.x;
            CMD_READ:  lane[0] = xf_mat[{c.row, c.col}];
            CMD_XFORM:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    lane[i] = dot_row(i, v, ovf);
                end
            end
            CMD_TRANS:
            begin
                // all four dot products use the old column 3
                for (int i = 0; i < 4; i++)
                begin
                    col3[i] = dot_row(i, v, ovf);
                end
                for (int i = 0; i < 4; i++)
                begin
                    xf_mat[i*4 + 3] = col3[i];
                end
            end
            CMD_SCALE:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    xf_mat[i] = clamp32(q_mul(xf_mat[i], v[i % 4]), ovf);
                end
            end
            CMD_IDENT: load_identity();
            default:   ;
        endcase
        r.x   = lane[0];
        r.y   = lane[1];
        r.z   = lane[2];
        r.w   = lane[3];
        r.ovf = ovf;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic word_t rand_q();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return word_t'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
            5, 6:          return Q_ONE + word_t'($urandom_range(0, 255)) - 32'sd128;
            7:             return word_t'($urandom);
            8:
            begin
                case ($urandom_range(0, 5))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    3:       return -32'sd1;
                    4:       return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
            default:       return word_t'($urandom_range(0, 65535)) - 32'sh8000;
        endcase
    endfunction

    // mostly +/-1.0 with a small wobble, so repeated scaling stays in range
    function automatic word_t scale_q();
        if ($urandom_range(0, 4) == 0)
            return rand_q();
        return (($urandom_range(0, 1) != 0) ? Q_ONE : -Q_ONE)
               + word_t'($urandom_range(0, 4095)) - 32'sd2048;
    endfunction

    task automatic queue_cmd(cmd_t c, idx_t r, idx_t k, word_t x, word_t y, word_t z, word_t w);
        cmd_word_t item;
        item.cmd = c;
        item.row = r;
        item.col = k;
        item.x   = x;
        item.y   = y;
        item.z   = z;
        item.w   = w;
        cmd_backlog.push_back(item);
        queued_cnt++;
    endtask

    task automatic fill_random(int n_items);
        int stop_at;
        stop_at = queued_cnt + n_items;
        while (queued_cnt < stop_at)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                // set up a matrix, stream vertices through it, read some back
                if ($urandom_range(0, 2) == 0)
                    queue_cmd(CMD_IDENT, idx_t'($urandom), idx_t'($urandom),
                              word_t'($urandom), word_t'($urandom),
                              word_t'($urandom), word_t'($urandom));
                repeat ($urandom_range(0, 3))
                    queue_cmd(CMD_WRITE, idx_t'($urandom), idx_t'($urandom),
                              rand_q(), rand_q(), rand_q(), rand_q());
                repeat ($urandom_range(0, 2))
                begin
                    if ($urandom_range(0, 1) != 0)
                        queue_cmd(CMD_TRANS, idx_t'($urandom), idx_t'($urandom),
                                  rand_q(), rand_q(), rand_q(),
                                  ($urandom_range(0, 3) != 0) ? Q_ONE : rand_q());
                    else
                        queue_cmd(CMD_SCALE, idx_t'($urandom), idx_t'($urandom),
                                  scale_q(), scale_q(), scale_q(), scale_q());
                end
                repeat ($urandom_range(3, 8))
                    queue_cmd(CMD_XFORM, idx_t'($urandom), idx_t'($urandom),
                              rand_q(), rand_q(), rand_q(),
                              ($urandom_range(0, 3) != 0) ? Q_ONE : rand_q());
                repeat ($urandom_range(0, 4))
                    queue_cmd(CMD_READ, idx_t'($urandom), idx_t'($urandom),
                              word_t'($urandom), word_t'($urandom),
                              word_t'($urandom), word_t'($urandom));
            end
            else
            begin
                queue_cmd(cmd_t'($urandom_range(0, 7)), idx_t'($urandom), idx_t'($urandom),
                          word_t'($urandom), rand_q(), rand_q(), word_t'($urandom));
            end
        end
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (drv_valid && req_ch.ready)
                pending_results.push_back(apply_command(drv_word));
            if (!drv_valid || req_ch.ready)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    drv_word  <= cmd_backlog.pop_front();
                    drv_valid <= 1'b1;
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic check_field(string name, word_t want, word_t got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && sink_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with no command outstanding");
                    mismatch_cnt++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("res_x", want.x, rsp_ch.res_x);
                    check_field("res_y", want.y, rsp_ch.res_y);
                    check_field("res_z", want.z, rsp_ch.res_z);
                    check_field("res_w", want.w, rsp_ch.res_w);
                    check_field("overflow", word_t'(want.ovf), word_t'(rsp_ch.overflow));
                end
            end
            sink_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        load_identity();

        // identity after reset, floor on negative products, saturation both ways
        queue_cmd(CMD_READ,  2'd0, 2'd0, '0, '0, '0, '0);
        queue_cmd(CMD_READ,  2'd3, 2'd2, '0, '0, '0, '0);
        queue_cmd(CMD_XFORM, 2'd0, 2'd0, Q_ONE, 2 * Q_ONE, -3 * Q_ONE, Q_ONE);
        queue_cmd(CMD_WRITE, 2'd0, 2'd0, Q_MAX, '0, '0, '0);
        queue_cmd(CMD_WRITE, 2'd3, 2'd3, Q_MIN, '0, '0, '0);
        queue_cmd(CMD_XFORM, 2'd0, 2'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        queue_cmd(CMD_XFORM, 2'd0, 2'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        queue_cmd(CMD_READ,  2'd0, 2'd0, '0, '0, '0, '0);
        queue_cmd(CMD_IDENT, 2'd0, 2'd0, '0, '0, '0, '0);
        queue_cmd(CMD_WRITE, 2'd1, 2'd1, 32'sd1, '0, '0, '0);
        queue_cmd(CMD_XFORM, 2'd0, 2'd0, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
        queue_cmd(CMD_XFORM, 2'd0, 2'd0, '0, '0, '0, '0);
        queue_cmd(CMD_TRANS, 2'd0, 2'd0, 3 * Q_ONE, -2 * Q_ONE, Q_ONE / 2, Q_ONE);
        queue_cmd(CMD_READ,  2'd0, 2'd3, '0, '0, '0, '0);
        queue_cmd(CMD_READ,  2'd3, 2'd3, '0, '0, '0, '0);
        queue_cmd(CMD_SCALE, 2'd0, 2'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        queue_cmd(CMD_READ,  2'd0, 2'd3, '0, '0, '0, '0);
        queue_cmd(CMD_SCALE, 2'd0, 2'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        queue_cmd(CMD_TRANS, 2'd0, 2'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        queue_cmd(CMD_RSVD6, 2'd3, 2'd3, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
        queue_cmd(CMD_RSVD7, 2'd0, 2'd0, '0, '0, '0, '0);
        queue_cmd(CMD_READ,  2'd1, 2'd1, '0, '0, '0, '0);
        queue_cmd(CMD_IDENT, 2'd3, 2'd3, '0, '0, '0, '0);
        queue_cmd(CMD_XFORM, 2'd0, 2'd0, Q_MIN, Q_MAX, '0, Q_ONE);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            fill_random(350);
            while (cmd_backlog.size() != 0 || drv_valid || pending_results.size() != 0)
                @(posedge clk);
        end

        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: matrix4_vertex_transform_unit.f
+incdir+src
src/m4vt_pkg.sv
src/m4vt_req_if.sv
src/m4vt_rsp_if.sv
src/m4vt_mul.sv
src/m4vt_sat.sv
src/matrix4_vertex_transform_unit.sv
dv/tb.sv
